// ===== rtl/r2fft_pkg.sv =====
package r2fft_pkg;

  localparam int MAX_LOG2_POINTS_DEF = 12;
  localparam int INTERNAL_WIDTH_DEF  = 32;
  localparam int TWIDDLE_WIDTH_DEF   = 16;

  localparam int SAMPLE_W   = 16;
  localparam int BIN_W      = 32;
  localparam int LOG2_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int TW_SLOT_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_LOG2_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE   = 4'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] WSEL_SAMPLE = 3'd0;
  localparam logic [2:0] WSEL_RDATA  = 3'd1;
  localparam logic [2:0] WSEL_AREG   = 3'd2;
  localparam logic [2:0] WSEL_SUM    = 3'd3;
  localparam logic [2:0] WSEL_DIFF   = 3'd4;
  localparam logic [2:0] WSEL_SCALE  = 3'd5;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;
  localparam int SERIES_TERMS = 13;

  typedef struct packed {
    logic       we;
    logic [2:0] wsel;
    logic       cap_a;
    logic       cap_b;
    logic       mul_en;
    logic       comb_en;
    logic       out_ld;
    logic       out_err;
    logic       out_last;
    logic       inverse;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[123:60];
  endfunction

  // Unsigned quotient by shift and subtract, used only while building the table.
  function automatic logic [63:0] q60_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [TW_SLOT_W-1:0] q60_to_tw(logic [63:0] v, int tf);
    logic [63:0] r;
    logic [63:0] top;
    top = (64'd1 << tf) - 64'd1;
    if (v[63]) begin
      return '0;
    end
    r = (v + (64'd1 << (59 - tf))) >> (60 - tf);
    if (r > top) begin
      r = top;
    end
    return r[TW_SLOT_W-1:0];
  endfunction

  // Cosine and sine of pi*m/nhalf in the first quadrant, {cos, sin}.
  function automatic logic [2*TW_SLOT_W-1:0] tw_quadrant(int m, int maxl, int tf);
    logic [127:0] p;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum_s;
    logic [63:0]  sum_c;
    logic [63:0]  dv;
    p = PI_Q60 * 128'(m);
    p = p >> (maxl - 1);
    x = p[63:0];
    x2 = q60_mul(x, x);
    term = x;
    sum_s = x;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      dv = 64'((2 * n) * (2 * n + 1));
      term = q60_div(q60_mul(term, x2), dv);
      sum_s = n[0] ? sum_s - term : sum_s + term;
    end
    term = ONE_Q60;
    sum_c = ONE_Q60;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      dv = 64'((2 * n - 1) * (2 * n));
      term = q60_div(q60_mul(term, x2), dv);
      sum_c = n[0] ? sum_c - term : sum_c + term;
    end
    return {q60_to_tw(sum_c, tf), q60_to_tw(sum_s, tf)};
  endfunction

  // Twiddle k of the half circle, {cos, sin}, two's complement slots.
  function automatic logic [2*TW_SLOT_W-1:0] tw_entry(int k, int maxl, int tf);
    logic [2*TW_SLOT_W-1:0] q;
    int nhalf;
    nhalf = 1 << (maxl - 1);
    if (2 * k <= nhalf) begin
      q = tw_quadrant(k, maxl, tf);
      return q;
    end
    q = tw_quadrant(nhalf - k, maxl, tf);
    return {-q[2*TW_SLOT_W-1:TW_SLOT_W], q[TW_SLOT_W-1:0]};
  endfunction

endpackage

// ===== rtl/r2fft_in_if.sv =====
interface r2fft_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re;
  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im;

  modport source(output valid, operation, sample_re, sample_im, input ready);
  modport sink(input valid, operation, sample_re, sample_im, output ready);
endinterface

// ===== rtl/r2fft_out_if.sv =====
interface r2fft_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [r2fft_pkg::BIN_W-1:0] bin_re;
  logic signed [r2fft_pkg::BIN_W-1:0] bin_im;
  logic                               last_bin;
  logic                               status;

  modport source(output valid, bin_re, bin_im, last_bin, status, input ready);
  modport sink(input valid, bin_re, bin_im, last_bin, status, output ready);
endinterface

// ===== rtl/r2fft_cfg_if.sv =====
interface r2fft_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [r2fft_pkg::CFG_IDX_W-1:0]     index;
  logic [r2fft_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/r2fft_ram.sv =====
module r2fft_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/r2fft_tw_rom.sv =====
module r2fft_tw_rom #(
  parameter int MAX_LOG2_POINTS = r2fft_pkg::MAX_LOG2_POINTS_DEF,
  parameter int TWIDDLE_WIDTH   = r2fft_pkg::TWIDDLE_WIDTH_DEF,
  localparam int TAW   = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1,
  localparam int NHALF = 1 << (MAX_LOG2_POINTS - 1)
) (
  input  logic                            clk,
  input  logic [TAW-1:0]                  addr,
  output logic signed [TWIDDLE_WIDTH-1:0] cos_q,
  output logic signed [TWIDDLE_WIDTH-1:0] sin_q
);

  localparam int SW = r2fft_pkg::TW_SLOT_W;

  logic [2*SW-1:0] rom [NHALF];

  for (genvar k = 0; k < NHALF; k++) begin : g_rom
    localparam logic [2*SW-1:0] ENTRY =
      r2fft_pkg::tw_entry(k, MAX_LOG2_POINTS, TWIDDLE_WIDTH - 1);
    assign rom[k] = ENTRY;
  end

  logic [2*SW-1:0] word;

  always_comb begin
    word = '0;
    if (int'(addr) < NHALF) begin
      word = rom[addr];
    end
  end

  always_ff @(posedge clk) begin
    cos_q <= word[SW+TWIDDLE_WIDTH-1:SW];
    sin_q <= word[TWIDDLE_WIDTH-1:0];
  end

endmodule

// ===== rtl/r2fft_dp.sv =====
module r2fft_dp #(
  parameter int MAX_LOG2_POINTS = r2fft_pkg::MAX_LOG2_POINTS_DEF,
  parameter int INTERNAL_WIDTH  = r2fft_pkg::INTERNAL_WIDTH_DEF,
  parameter int TWIDDLE_WIDTH   = r2fft_pkg::TWIDDLE_WIDTH_DEF,
  localparam int AW  = MAX_LOG2_POINTS,
  localparam int TAW = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1,
  localparam int BW  = $clog2(MAX_LOG2_POINTS + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  r2fft_pkg::dp_cmd_t                    cmd,
  output r2fft_pkg::dp_status_t                 status,
  input  logic [AW-1:0]                         rd_addr,
  input  logic [AW-1:0]                         wr_addr,
  input  logic [TAW-1:0]                        tw_addr,
  input  logic [BW-1:0]                         bits,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im,
  r2fft_out_if.source                           result
);

  localparam int IW = INTERNAL_WIDTH;
  localparam int PW = INTERNAL_WIDTH + TWIDDLE_WIDTH;
  localparam int TF = TWIDDLE_WIDTH - 1;
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (TWIDDLE_WIDTH - 2);

  logic [2*IW-1:0]                 rdata;
  logic [2*IW-1:0]                 wdata;
  logic signed [IW-1:0]            rd_re;
  logic signed [IW-1:0]            rd_im;
  logic signed [IW-1:0]            a_re;
  logic signed [IW-1:0]            a_im;
  logic signed [IW-1:0]            b_re;
  logic signed [IW-1:0]            b_im;
  logic signed [IW-1:0]            m_rr;
  logic signed [IW-1:0]            m_ii;
  logic signed [IW-1:0]            m_ri;
  logic signed [IW-1:0]            m_ir;
  logic signed [IW-1:0]            pr;
  logic signed [IW-1:0]            pi;
  logic signed [TWIDDLE_WIDTH-1:0] tw_cos;
  logic signed [TWIDDLE_WIDTH-1:0] tw_sin;
  logic signed [TWIDDLE_WIDTH-1:0] wi;
  logic signed [PW-1:0]            p_rr;
  logic signed [PW-1:0]            p_ii;
  logic signed [PW-1:0]            p_ri;
  logic signed [PW-1:0]            p_ir;
  logic                            out_valid;

  r2fft_ram #(
    .WIDTH(2 * IW),
    .DEPTH(1 << MAX_LOG2_POINTS)
  ) u_frame (
    .clk  (clk),
    .we   (cmd.we),
    .waddr(wr_addr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  r2fft_tw_rom #(
    .MAX_LOG2_POINTS(MAX_LOG2_POINTS),
    .TWIDDLE_WIDTH  (TWIDDLE_WIDTH)
  ) u_tw (
    .clk  (clk),
    .addr (tw_addr),
    .cos_q(tw_cos),
    .sin_q(tw_sin)
  );

  assign rd_re = rdata[2*IW-1:IW];
  assign rd_im = rdata[IW-1:0];
  assign wi    = cmd.inverse ? tw_sin : -tw_sin;

  assign p_rr = PW'(b_re) * PW'(tw_cos);
  assign p_ii = PW'(b_im) * PW'(wi);
  assign p_ri = PW'(b_re) * PW'(wi);
  assign p_ir = PW'(b_im) * PW'(tw_cos);

  always_comb begin
    wdata = rdata;
    case (cmd.wsel)
      r2fft_pkg::WSEL_SAMPLE: wdata = {IW'(sample_re), IW'(sample_im)};
      r2fft_pkg::WSEL_RDATA:  wdata = rdata;
      r2fft_pkg::WSEL_AREG:   wdata = {a_re, a_im};
      r2fft_pkg::WSEL_SUM:    wdata = {a_re + pr, a_im + pi};
      r2fft_pkg::WSEL_DIFF:   wdata = {a_re - pr, a_im - pi};
      r2fft_pkg::WSEL_SCALE:  wdata = {rd_re >>> bits, rd_im >>> bits};
      default:                wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_re <= rd_re;
      a_im <= rd_im;
    end
    if (cmd.cap_b) begin
      b_re <= rd_re;
      b_im <= rd_im;
    end
    if (cmd.mul_en) begin
      m_rr <= IW'((p_rr + RND) >>> TF);
      m_ii <= IW'((p_ii + RND) >>> TF);
      m_ri <= IW'((p_ri + RND) >>> TF);
      m_ir <= IW'((p_ir + RND) >>> TF);
    end
    if (cmd.comb_en) begin
      pr <= m_rr - m_ii;
      pi <= m_ri + m_ir;
    end
    if (cmd.out_ld) begin
      result.bin_re   <= cmd.out_err ? '0 : r2fft_pkg::BIN_W'(rd_re);
      result.bin_im   <= cmd.out_err ? '0 : r2fft_pkg::BIN_W'(rd_im);
      result.last_bin <= cmd.out_last;
      result.status   <= cmd.out_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid    = out_valid;
  assign status.out_full = out_valid;

endmodule

// ===== rtl/r2fft_ctrl.sv =====
module r2fft_ctrl #(
  parameter int MAX_LOG2_POINTS = r2fft_pkg::MAX_LOG2_POINTS_DEF,
  localparam int AW  = MAX_LOG2_POINTS,
  localparam int CW  = MAX_LOG2_POINTS + 1,
  localparam int TAW = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1,
  localparam int BW  = $clog2(MAX_LOG2_POINTS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  operation,
  r2fft_cfg_if.sink             cfg,
  input  r2fft_pkg::dp_status_t status,
  output r2fft_pkg::dp_cmd_t    cmd,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr,
  output logic [TAW-1:0]        tw_addr,
  output logic [BW-1:0]         bits
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD_W  = 4'd1;
  localparam logic [3:0] S_REV_A = 4'd2;
  localparam logic [3:0] S_REV_B = 4'd3;
  localparam logic [3:0] S_REV_C = 4'd4;
  localparam logic [3:0] S_REV_D = 4'd5;
  localparam logic [3:0] S_BF_Q  = 4'd6;
  localparam logic [3:0] S_BF_P  = 4'd7;
  localparam logic [3:0] S_BF_M  = 4'd8;
  localparam logic [3:0] S_BF_C  = 4'd9;
  localparam logic [3:0] S_BF_WP = 4'd10;
  localparam logic [3:0] S_BF_WQ = 4'd11;
  localparam logic [3:0] S_SC_R  = 4'd12;
  localparam logic [3:0] S_SC_W  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]                     state;
  logic [3:0]                     state_next;
  logic [CW-1:0]                  load_count;
  logic [CW-1:0]                  load_count_next;
  logic [CW-1:0]                  read_count;
  logic [CW-1:0]                  read_count_next;
  logic                           results_ready;
  logic                           results_ready_next;
  logic [AW-1:0]                  idx;
  logic [AW-1:0]                  idx_next;
  logic [AW-1:0]                  bf;
  logic [AW-1:0]                  bf_next;
  logic [BW-1:0]                  stage;
  logic [BW-1:0]                  stage_next;
  logic [r2fft_pkg::LOG2_W-1:0]   log2_size;
  logic                           inverse_mode;

  logic [CW-1:0] n_pts;
  logic [AW-1:0] nm1;
  logic [AW-1:0] rev_full;
  logic [AW-1:0] rev_r;
  logic [AW-1:0] half;
  logic [AW-1:0] jmask;
  logic [AW-1:0] j_idx;
  logic [AW-1:0] p_addr;
  logic [AW-1:0] q_addr;
  logic [AW-1:0] k_full;
  logic          accept;
  logic          rev_last;

  always_comb begin
    if (log2_size == '0) begin
      bits = BW'(1);
    end else if (int'(log2_size) > MAX_LOG2_POINTS) begin
      bits = BW'(MAX_LOG2_POINTS);
    end else begin
      bits = BW'(log2_size);
    end
  end

  assign n_pts = CW'(1) << bits;
  assign nm1   = AW'(n_pts - CW'(1));

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = idx[AW-1-b];
    end
  end

  assign rev_r    = rev_full >> (AW - int'(bits));
  assign rev_last = (idx == nm1);

  assign half   = AW'(CW'(1) << (stage - BW'(1)));
  assign jmask  = half - AW'(1);
  assign j_idx  = bf & jmask;
  assign p_addr = ((bf >> (stage - BW'(1))) << stage) | j_idx;
  assign q_addr = p_addr | half;
  assign k_full = j_idx << (MAX_LOG2_POINTS - int'(stage));
  assign tw_addr = k_full[TAW-1:0];

  assign item_ready = (state == S_IDLE) && !status.out_full;
  assign accept     = item_valid && item_ready;
  assign cfg.ready  = 1'b1;

  always_comb begin
    state_next         = state;
    load_count_next    = load_count;
    read_count_next    = read_count;
    results_ready_next = results_ready;
    idx_next           = idx;
    bf_next            = bf;
    stage_next         = stage;
    cmd                = '0;
    cmd.inverse        = inverse_mode;
    rd_addr            = idx;
    wr_addr            = idx;
    unique case (state)
      S_IDLE: begin
        if (accept && operation == r2fft_pkg::OP_LOAD) begin
          cmd.we             = 1'b1;
          cmd.wsel           = r2fft_pkg::WSEL_SAMPLE;
          wr_addr            = load_count[AW-1:0];
          results_ready_next = 1'b0;
          read_count_next    = '0;
          load_count_next    = load_count + CW'(1);
          if (load_count + CW'(1) >= n_pts) begin
            idx_next   = '0;
            state_next = S_REV_A;
          end
        end else if (accept) begin
          if (results_ready && read_count < n_pts) begin
            rd_addr    = read_count[AW-1:0];
            state_next = S_RD_W;
          end else begin
            cmd.out_ld         = 1'b1;
            cmd.out_err        = 1'b1;
            results_ready_next = 1'b0;
            read_count_next    = '0;
          end
        end
      end
      S_RD_W: begin
        cmd.out_ld   = 1'b1;
        cmd.out_last = (read_count == CW'(nm1));
        if (read_count == CW'(nm1)) begin
          results_ready_next = 1'b0;
          read_count_next    = '0;
        end else begin
          read_count_next = read_count + CW'(1);
        end
        state_next = S_IDLE;
      end
      S_REV_A: begin
        if (idx < rev_r) begin
          state_next = S_REV_B;
        end else if (rev_last) begin
          stage_next = BW'(1);
          bf_next    = '0;
          state_next = S_BF_Q;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      S_REV_B: begin
        rd_addr    = rev_r;
        cmd.cap_a  = 1'b1;
        state_next = S_REV_C;
      end
      S_REV_C: begin
        cmd.we     = 1'b1;
        cmd.wsel   = r2fft_pkg::WSEL_RDATA;
        state_next = S_REV_D;
      end
      S_REV_D: begin
        cmd.we   = 1'b1;
        cmd.wsel = r2fft_pkg::WSEL_AREG;
        wr_addr  = rev_r;
        if (rev_last) begin
          stage_next = BW'(1);
          bf_next    = '0;
          state_next = S_BF_Q;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_REV_A;
        end
      end
      S_BF_Q: begin
        rd_addr    = q_addr;
        state_next = S_BF_P;
      end
      S_BF_P: begin
        rd_addr    = p_addr;
        cmd.cap_b  = 1'b1;
        state_next = S_BF_M;
      end
      S_BF_M: begin
        cmd.cap_a  = 1'b1;
        cmd.mul_en = 1'b1;
        state_next = S_BF_C;
      end
      S_BF_C: begin
        cmd.comb_en = 1'b1;
        state_next  = S_BF_WP;
      end
      S_BF_WP: begin
        cmd.we     = 1'b1;
        cmd.wsel   = r2fft_pkg::WSEL_SUM;
        wr_addr    = p_addr;
        state_next = S_BF_WQ;
      end
      S_BF_WQ: begin
        cmd.we   = 1'b1;
        cmd.wsel = r2fft_pkg::WSEL_DIFF;
        wr_addr  = q_addr;
        if (bf == (nm1 >> 1)) begin
          bf_next = '0;
          if (stage == bits) begin
            idx_next   = '0;
            state_next = inverse_mode ? S_SC_R : S_DONE;
          end else begin
            stage_next = stage + BW'(1);
            state_next = S_BF_Q;
          end
        end else begin
          bf_next    = bf + AW'(1);
          state_next = S_BF_Q;
        end
      end
      S_SC_R: begin
        state_next = S_SC_W;
      end
      S_SC_W: begin
        cmd.we   = 1'b1;
        cmd.wsel = r2fft_pkg::WSEL_SCALE;
        if (rev_last) begin
          state_next = S_DONE;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_SC_R;
        end
      end
      S_DONE: begin
        results_ready_next = 1'b1;
        load_count_next    = '0;
        read_count_next    = '0;
        state_next         = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_count    <= '0;
      read_count    <= '0;
      results_ready <= 1'b0;
      idx           <= '0;
      bf            <= '0;
      stage         <= BW'(1);
      log2_size     <= r2fft_pkg::LOG2_W'(10);
      inverse_mode  <= 1'b0;
    end else begin
      state         <= state_next;
      load_count    <= load_count_next;
      read_count    <= read_count_next;
      results_ready <= results_ready_next;
      idx           <= idx_next;
      bf            <= bf_next;
      stage         <= stage_next;
      if (cfg.valid && cfg.index == r2fft_pkg::REG_LOG2_SIZE) begin
        log2_size <= cfg.data[r2fft_pkg::LOG2_W-1:0];
      end
      if (cfg.valid && cfg.index == r2fft_pkg::REG_INVERSE) begin
        inverse_mode <= cfg.data[0];
      end
    end
  end

`ifndef SYNTHESIS
  a_last_bin_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_ld && cmd.out_last) |=> !results_ready)
    else $error("results still pending after the last bin");

  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_REV_B) |-> (idx < rev_r))
    else $error("bit-reversal swap issued for an ordered pair");

  a_bfly_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_BF_WP) |-> (p_addr < q_addr))
    else $error("butterfly lower address not below upper address");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (results_ready && load_count == '0 && read_count == '0))
    else $error("transform end did not arm the result read-out");
`endif

endmodule

// ===== rtl/radix2_fft_frame.sv =====
// Channel   Role    Payload
// item      sink    operation, sample_re, sample_im
// result    source  bin_re, bin_im, last_bin, status
// cfg       sink    index (0 log2_size, 1 inverse_mode), data
//
// The load that completes a frame starts the transform. Bit reversal checks
// every index and swaps each out-of-order pair; then N*log2(N)/2 butterflies
// run through the single read port of the frame memory; inverse mode then
// scales every index; a final step arms the result read-out. A read of a bin
// passes through the registered memory read before the result register.
// Reset is synchronous and clears control state only; the frame memory is not
// cleared. A new item is taken only while idle and the result register is empty.
module radix2_fft_frame #(
  parameter int MAX_LOG2_POINTS = r2fft_pkg::MAX_LOG2_POINTS_DEF,
  parameter int INTERNAL_WIDTH  = r2fft_pkg::INTERNAL_WIDTH_DEF,
  parameter int TWIDDLE_WIDTH   = r2fft_pkg::TWIDDLE_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  r2fft_in_if.sink    item,
  r2fft_out_if.source result,
  r2fft_cfg_if.sink   cfg
);

  localparam int AW  = MAX_LOG2_POINTS;
  localparam int TAW = (MAX_LOG2_POINTS > 1) ? MAX_LOG2_POINTS - 1 : 1;
  localparam int BW  = $clog2(MAX_LOG2_POINTS + 1);

  r2fft_pkg::dp_cmd_t    cmd;
  r2fft_pkg::dp_status_t status;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [TAW-1:0]        tw_addr;
  logic [BW-1:0]         bits;
  logic                  item_ready;

  assign item.ready = item_ready;

  r2fft_ctrl #(
    .MAX_LOG2_POINTS(MAX_LOG2_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .item_ready(item_ready),
    .operation (item.operation),
    .cfg       (cfg),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .tw_addr   (tw_addr),
    .bits      (bits)
  );

  r2fft_dp #(
    .MAX_LOG2_POINTS(MAX_LOG2_POINTS),
    .INTERNAL_WIDTH (INTERNAL_WIDTH),
    .TWIDDLE_WIDTH  (TWIDDLE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .tw_addr  (tw_addr),
    .bits     (bits),
    .sample_re(item.sample_re),
    .sample_im(item.sample_im),
    .result   (result)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EMPTY = 1'b1;
  localparam int   NMAX       = 4096;
  localparam int   WATCHDOG   = 20000;
  localparam int   RAND_ITEMS = 800;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
    logic        status;
  } bin_t;

  typedef struct packed {
    bit          is_cfg;
    logic [3:0]  idx;
    logic [7:0]  data;
    logic        op;
    logic [15:0] re;
    logic [15:0] im;
    bit          empty_read;
  } row_t;

  logic clk;
  logic rst;

  r2fft_in_if  item_ch();
  r2fft_out_if res_ch();
  r2fft_cfg_if cfg_ch();

  radix2_fft_frame u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(res_ch),
    .cfg   (cfg_ch)
  );

  int          tw_cos [NMAX/2];
  int          tw_sin [NMAX/2];
  logic [31:0] buf_re [NMAX];
  logic [31:0] buf_im [NMAX];
  logic [3:0]  size_reg;
  logic        inv_reg;
  int          load_cnt;
  int          read_cnt;
  bit          bins_ready;
  int          settle;
  int          errors;
  int          items_sent;
  int          idle_cycles;
  int          stall_left;
  bit          no_idle;
  bin_t        bin_q[$];

  function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic int q60_round(logic [63:0] v);
    logic [63:0] r;
    if (v[63]) begin
      return 0;
    end
    r = (v + (64'd1 << 44)) >> 45;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return int'(r);
  endfunction

  task automatic build_twiddles();
    logic [127:0] p;
    logic [63:0]  x, x2, term, s_sum, c_sum;
    int           m;
    for (int k = 0; k < NMAX / 2; k++) begin
      m = (2 * k <= NMAX / 2) ? k : NMAX / 2 - k;
      p = 128'(r2fft_pkg::PI_Q60) * 128'(m);
      p = p >> 11;
      x = p[63:0];
      x2 = q60_product(x, x);
      term = x;
      s_sum = x;
      for (int n = 1; n <= r2fft_pkg::SERIES_TERMS; n++) begin
        term = q60_product(term, x2) / 64'((2 * n) * (2 * n + 1));
        s_sum = n[0] ? s_sum - term : s_sum + term;
      end
      term = r2fft_pkg::ONE_Q60;
      c_sum = r2fft_pkg::ONE_Q60;
      for (int n = 1; n <= r2fft_pkg::SERIES_TERMS; n++) begin
        term = q60_product(term, x2) / 64'((2 * n - 1) * (2 * n));
        c_sum = n[0] ? c_sum - term : c_sum + term;
      end
      tw_cos[k] = (2 * k <= NMAX / 2) ? q60_round(c_sum) : -q60_round(c_sum);
      tw_sin[k] = q60_round(s_sum);
    end
  endtask

  function automatic logic [31:0] mul_round(logic [31:0] a, int t);
    longint pr;
    pr = longint'($signed(a)) * longint'(t);
    return 32'((pr + 64'sd16384) >>> 15);
  endfunction

  function automatic int eff_log2();
    if (size_reg < 4'd1) begin
      return 1;
    end
    if (size_reg > 4'd12) begin
      return 12;
    end
    return int'(size_reg);
  endfunction

  task automatic run_fft(int bits);
    int          n, r, half, stride, p, q, k, wr, wi;
    logic [31:0] t, br, bi, pr, pim, ar, ai;
    n = 1 << bits;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < bits; b++) begin
        r = (r << 1) | ((i >> b) & 1);
      end
      if (i < r) begin
        t = buf_re[i]; buf_re[i] = buf_re[r]; buf_re[r] = t;
        t = buf_im[i]; buf_im[i] = buf_im[r]; buf_im[r] = t;
      end
    end
    for (int len = 2; len <= n; len <<= 1) begin
      half = len / 2;
      stride = NMAX / len;
      for (int i = 0; i < n; i += len) begin
        for (int j = 0; j < half; j++) begin
          p = i + j;
          q = i + j + half;
          k = (j * stride) & (NMAX / 2 - 1);
          wr = tw_cos[k];
          wi = inv_reg ? tw_sin[k] : -tw_sin[k];
          br = buf_re[q];
          bi = buf_im[q];
          pr = mul_round(br, wr) - mul_round(bi, wi);
          pim = mul_round(br, wi) + mul_round(bi, wr);
          ar = buf_re[p];
          ai = buf_im[p];
          buf_re[p] = ar + pr;
          buf_im[p] = ai + pim;
          buf_re[q] = ar - pr;
          buf_im[q] = ai - pim;
        end
      end
    end
    if (inv_reg) begin
      for (int i = 0; i < n; i++) begin
        buf_re[i] = $signed(buf_re[i]) >>> bits;
        buf_im[i] = $signed(buf_im[i]) >>> bits;
      end
    end
  endtask

  task automatic predict_bin(input logic op, input logic [15:0] re, input logic [15:0] im,
                             output bit has, output bin_t b);
    int bits, n;
    bit last;
    bits = eff_log2();
    n = 1 << bits;
    has = 0;
    b = '0;
    if (op == r2fft_pkg::OP_LOAD) begin
      if (bins_ready) begin
        bins_ready = 0;
        read_cnt = 0;
      end
      buf_re[load_cnt % NMAX] = {{16{re[15]}}, re};
      buf_im[load_cnt % NMAX] = {{16{im[15]}}, im};
      load_cnt++;
      if (load_cnt >= n) begin
        run_fft(bits);
        load_cnt = 0;
        read_cnt = 0;
        bins_ready = 1;
        settle = 3 * n * bits + 5 * n + (inv_reg ? 2 * n : 0) + 50;
      end
    end else begin
      has = 1;
      b.status = STAT_EMPTY;
      if (bins_ready && read_cnt < n) begin
        last = (read_cnt == n - 1);
        b.re = buf_re[read_cnt];
        b.im = buf_im[read_cnt];
        b.last = last;
        b.status = STAT_OK;
        read_cnt++;
        if (last) begin
          bins_ready = 0;
          read_cnt = 0;
        end
      end else if (bins_ready) begin
        bins_ready = 0;
        read_cnt = 0;
      end
    end
  endtask

  task automatic send_item(logic op, logic [15:0] re, logic [15:0] im, bit empty_read);
    bit   has;
    bin_t b;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.sample_re <= re;
    item_ch.sample_im <= im;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    predict_bin(op, re, im, has, b);
    if (empty_read) begin
      b = '0;
      b.status = STAT_EMPTY;
    end
    if (has) begin
      bin_q.push_back(b);
    end
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (bin_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [7:0] data);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == r2fft_pkg::REG_LOG2_SIZE) begin
      size_reg = data[3:0];
    end else if (idx == r2fft_pkg::REG_INVERSE) begin
      inv_reg = data[0];
    end
  endtask

  function automatic logic [15:0] rnd_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic full_frame(int extra_reads);
    int n, loads;
    n = 1 << eff_log2();
    loads = (load_cnt >= n) ? 1 : n - load_cnt;
    repeat (loads) send_item(r2fft_pkg::OP_LOAD, rnd_sample(), rnd_sample(), 0);
    repeat (n + extra_reads) begin
      send_item(r2fft_pkg::OP_READ, 16'($urandom), 16'($urandom), 0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      idle_cycles = 0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        settle = 20;
        if (bin_q.size() == 0) begin
          $display("%0t unexpected transaction: re %h im %h last %b status %b", $time,
                   res_ch.bin_re, res_ch.bin_im, res_ch.last_bin, res_ch.status);
          errors++;
        end else begin
          bin_t e;
          e = bin_q.pop_front();
          if (res_ch.bin_re !== e.re) begin
            $display("%0t bin_re expected %h actual %h", $time, e.re, res_ch.bin_re);
            errors++;
          end
          if (res_ch.bin_im !== e.im) begin
            $display("%0t bin_im expected %h actual %h", $time, e.im, res_ch.bin_im);
            errors++;
          end
          if (res_ch.last_bin !== e.last) begin
            $display("%0t last_bin expected %b actual %b", $time, e.last, res_ch.last_bin);
            errors++;
          end
          if (res_ch.status !== e.status) begin
            $display("%0t status expected %b actual %b", $time, e.status, res_ch.status);
            errors++;
          end
        end
      end
      if ((res_ch.valid && res_ch.ready) || (item_ch.valid && item_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    row_t rows [20];
    int   pick;
    rows = '{
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_READ, 16'h0000, 16'h0000, 1},
      '{1, r2fft_pkg::REG_LOG2_SIZE, 8'd1, r2fft_pkg::OP_LOAD, 16'h0000, 16'h0000, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_LOAD, 16'h7fff, 16'h8000, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_LOAD, 16'h8000, 16'h7fff, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_READ, 16'hffff, 16'hffff, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_READ, 16'h0000, 16'h0000, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_READ, 16'h0000, 16'h0000, 1},
      '{1, r2fft_pkg::REG_INVERSE, 8'd1, r2fft_pkg::OP_LOAD, 16'h0000, 16'h0000, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_LOAD, 16'h7fff, 16'h7fff, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_LOAD, 16'h8000, 16'h8000, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_READ, 16'h0000, 16'h0000, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_READ, 16'h0000, 16'h0000, 0},
      '{1, r2fft_pkg::REG_LOG2_SIZE, 8'd0, r2fft_pkg::OP_LOAD, 16'h0000, 16'h0000, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_LOAD, 16'h0001, 16'hffff, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_LOAD, 16'hffff, 16'h0001, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_READ, 16'h0000, 16'h0000, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_LOAD, 16'h0005, 16'h0005, 0},
      '{0, 4'd0, 8'd0, r2fft_pkg::OP_READ, 16'h0000, 16'h0000, 1},
      '{1, r2fft_pkg::REG_LOG2_SIZE, 8'hf3, r2fft_pkg::OP_LOAD, 16'h0000, 16'h0000, 0},
      '{1, 4'd7, 8'hff, r2fft_pkg::OP_LOAD, 16'h0000, 16'h0000, 0}
    };
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.operation <= r2fft_pkg::OP_LOAD;
    item_ch.sample_re <= '0;
    item_ch.sample_im <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    build_twiddles();
    size_reg = 4'd10;
    inv_reg = 1'b0;
    load_cnt = 0;
    read_cnt = 0;
    bins_ready = 0;
    settle = 20;
    errors = 0;
    items_sent = 0;
    no_idle = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_item(rows[i].op, rows[i].re, rows[i].im, rows[i].empty_read);
      end
    end
    full_frame(1);
    write_reg(r2fft_pkg::REG_INVERSE, 8'd0);

    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          pick = $urandom_range(1, 4);
        end else if (pick == 7) begin
          pick = $urandom_range(5, 6);
        end else if (pick == 8) begin
          pick = 0;
        end else begin
          pick = $urandom_range(1, 3);
        end
        write_reg(r2fft_pkg::REG_LOG2_SIZE, {4'($urandom), 4'(pick)});
        if ($urandom_range(0, 1) == 0) begin
          write_reg(r2fft_pkg::REG_INVERSE, 8'($urandom));
        end
        if ($urandom_range(0, 5) == 0) begin
          write_reg(4'($urandom_range(2, 15)), 8'($urandom));
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        full_frame(($urandom_range(0, 3) == 0) ? 1 : 0);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            send_item(r2fft_pkg::OP_READ, 16'($urandom), 16'($urandom), 0);
          end
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          send_item(logic'($urandom_range(0, 1)), rnd_sample(), rnd_sample(), 0);
        end
      end
    end

    no_idle = 1;
    write_reg(r2fft_pkg::REG_INVERSE, 8'd0);
    write_reg(r2fft_pkg::REG_LOG2_SIZE, 8'h05);
    full_frame(0);
    write_reg(r2fft_pkg::REG_INVERSE, 8'd1);
    write_reg(r2fft_pkg::REG_LOG2_SIZE, 8'h04);
    full_frame(0);

    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/r2fft_pkg.sv
rtl/r2fft_in_if.sv
rtl/r2fft_out_if.sv
rtl/r2fft_cfg_if.sv
rtl/r2fft_ram.sv
rtl/r2fft_tw_rom.sv
rtl/r2fft_dp.sv
rtl/r2fft_ctrl.sv
rtl/radix2_fft_frame.sv
tb/sv/tb_top.sv
